>>> rtl/malt_pkg.sv
// Shared types and constants for the motion activity level tracker.
package malt_pkg;

    localparam int HIST_DEPTH        = 6;
    localparam int DATA_W            = 8;
    localparam int CFG_IDX_W         = 2;
    localparam int WAKE_DELAY_DEF    = 30;
    localparam logic [3:0] LEVEL_MAX = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_PERIOD = 2'd2;

    typedef struct packed {
        logic [7:0] sample;
        logic       radio_busy;
    } t_in;

    typedef struct packed {
        logic [3:0] mobility_level;
        logic       measured;
    } t_out;

    typedef struct packed {
        logic [7:0] noise_floor;
        logic [7:0] window_length;
        logic [7:0] measure_period;
    } t_cfg;

    typedef struct packed {
        logic [HIST_DEPTH-1:0][7:0] peaks;
        logic [7:0]                 window_count;
        logic [7:0]                 window_min;
        logic [7:0]                 window_max;
        logic [7:0]                 countdown;
    } t_state;

endpackage

>>> rtl/motion_activity_level_tracker.sv
// Top level of the motion activity level tracker: state, config registers, output skid.
//
// One request on the input channel is one system tick: an accelerometer sample
// and a radio-busy flag. Every tick produces exactly one result on the output
// channel: the mobility level (0..15) and a flag telling whether the tick
// took a measurement. Both channels are valid/ready.
// All state updates for a tick happen at the edge that accepts it; the result
// is registered at that same edge, and one tick can be accepted every cycle
// while the receiver keeps taking results.
// The output side has a main register and one skid register: a request is
// still taken while one finished result waits, and o_in_ready drops only
// when both hold results, i.e. after a request was taken while the receiver stalled.
// Configuration is a plain write port (enable, index, 8-bit data), applied
// at the edge where i_cfg_we is high; writes to unused indexes are dropped.
// Reset (synchronous, active low) clears the history and window registers and
// the output valid flags, loads the config registers with their defaults and
// the countdown with WAKE_DELAY.
module motion_activity_level_tracker
    import malt_pkg::*;
#(
    parameter int WAKE_DELAY = WAKE_DELAY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_out   n_result;
    t_out   r_out;
    t_out   r_skid;
    logic   r_out_valid;
    logic   r_skid_valid;
    logic   accept;
    logic   take;

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign take        = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    malt_update u_update (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_in     (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_floor    <= 8'd0;
            r_cfg.window_length  <= 8'd90;
            r_cfg.measure_period <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NOISE_FLOOR:    r_cfg.noise_floor    <= i_cfg_data;
                REG_WINDOW_LENGTH:  r_cfg.window_length  <= i_cfg_data;
                REG_MEASURE_PERIOD: r_cfg.measure_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.peaks        <= '0;
            r_state.window_count <= 8'd0;
            r_state.window_min   <= 8'd0;
            r_state.window_max   <= 8'd0;
            r_state.countdown    <= 8'(WAKE_DELAY);
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                // skid drains into the main register, or the output empties
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || i_out_ready) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while main register is empty");

    a_countdown_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state.countdown != 8'd0) |=>
            (r_state.countdown == $past(r_state.countdown) - 8'd1))
        else $error("countdown did not decrement on a waiting tick");

    a_window_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_result.measured && !i_cfg_we) |=>
            (r_state.window_count < r_cfg.window_length || r_cfg.window_length == 8'd0))
        else $error("window count reached window length without a history shift");

    a_meas_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_result.measured && !i_cfg_we) |=>
            (r_state.countdown == r_cfg.measure_period))
        else $error("countdown not reloaded after a measurement");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

>>> rtl/malt_update.sv
// Per-tick next-state and result logic: measurement, peak raise, history shift, level.
module malt_update
    import malt_pkg::*;
(
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  t_in    i_in,
    output t_state o_state,
    output t_out   o_result
);

    logic       meas;
    logic       first;
    logic [7:0] cur_min;
    logic [7:0] cur_max;
    logic [7:0] span;
    logic [7:0] raised;
    logic       over_floor;
    logic [7:0] cnt_inc;
    logic [HIST_DEPTH-1:0][7:0] peaks_up;
    logic [HIST_DEPTH-1:0][7:0] peaks_nx;
    logic [8:0] sum;
    logic [6:0] quarter;

    assign meas  = (i_state.countdown == 8'd0) && !i_in.radio_busy;
    assign first = (i_state.window_count == 8'd0);

    always_comb begin
        cur_min = i_state.window_min;
        cur_max = i_state.window_max;
        if (first) begin
            cur_min = i_in.sample;
            cur_max = i_in.sample;
        end else begin
            if (i_in.sample < i_state.window_min) cur_min = i_in.sample;
            if (i_in.sample > i_state.window_max) cur_max = i_in.sample;
        end
    end

    assign span       = first ? 8'd0 : cur_max - cur_min;
    assign over_floor = span > i_cfg.noise_floor;
    assign raised     = span - i_cfg.noise_floor;
    assign cnt_inc    = i_state.window_count + 8'd1;

    always_comb begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            peaks_up[i] = (over_floor && raised > i_state.peaks[i]) ? raised : i_state.peaks[i];
        end
    end

    always_comb begin
        o_state  = i_state;
        peaks_nx = i_state.peaks;
        if (i_state.countdown != 8'd0) begin
            o_state.countdown = i_state.countdown - 8'd1;
        end else if (meas) begin
            o_state.countdown  = i_cfg.measure_period;
            o_state.window_min = cur_min;
            o_state.window_max = cur_max;
            if (cnt_inc >= i_cfg.window_length) begin
                // close the window: history ages by one slot, fresh zero at the front
                peaks_nx[0] = 8'd0;
                for (int i = 1; i < HIST_DEPTH; i++) begin
                    peaks_nx[i] = peaks_up[i-1];
                end
                o_state.window_count = 8'd0;
            end else begin
                peaks_nx             = peaks_up;
                o_state.window_count = cnt_inc;
            end
        end
        o_state.peaks = peaks_nx;
    end

    // weighted history: slot i contributes peak >> (i+1); total stays below 256
    always_comb begin
        sum = 9'd0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            sum = sum + {1'b0, peaks_nx[i] >> (i + 1)};
        end
    end

    assign quarter = sum[7:2] > 6'(LEVEL_MAX) ? 7'(LEVEL_MAX) : {1'b0, sum[7:2]};

    assign o_result.mobility_level = quarter[3:0];
    assign o_result.measured       = meas;

endmodule
